// ===== src/quadratic_root_solver_top_assert.svh =====
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define QRS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic root solver check failed");
// Check that cons holds in the cycle after ante.
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");
`else
`define QRS_ASSERT_IMPL(label, ante, cons)
`define QRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/qrs_pkg.sv =====
// Types and constants of the quadratic root solver.
package qrs_pkg;

    // Root kind codes
    localparam logic [1:0] KIND_TWO_REAL = 2'd0;
    localparam logic [1:0] KIND_DOUBLE   = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;
    localparam logic [1:0] KIND_A_ZERO   = 2'd3;

    // Datapath widths
    localparam int COEF_W = 16;
    localparam int DISC_W = 34;
    localparam int SQ_W   = 25;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int REM_W  = SQ_W + 1;
    localparam int NUM_W  = 26;
    localparam int QUO_W  = 32;
    localparam int DIV_W  = 16;
    localparam int VAL_W  = 32;

    // Cycles from an accepted word to its result strobe
    localparam int PIPE_LAT = SQ_W + QUO_W + 4;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic [1:0]              root_kind;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] second_value;
        logic                    saturated;
    } qrs_out_t;

    // Side data carried along the square root stages
    typedef struct packed {
        logic [1:0]               kind;
        logic                     a_neg;
        logic [DIV_W-1:0]         a_mag;
        logic signed [NUM_W-2:0]  negb;
    } qrs_side_t;

    // Side data carried along the divider stages
    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       neg;
        logic [DIV_W-1:0] dsr;
    } qrs_dside_t;

endpackage

// ===== src/quadratic_root_solver_top.sv =====
// Pipelined quadratic root solver: discriminant, square root, two dividers, clamp.
//
// Usage: drive a coefficient word on coef and raise start; the word is taken at
// a rising edge where start is high and busy is low. Busy is high only in the
// first cycle after reset, so one word may enter on every cycle after that.
// Each word yields exactly one result word on result, marked by done for one
// cycle; the receiver has to take it in that cycle, it cannot hold results off.
// Throughput is one word per cycle. The pipeline is the digit-by-digit square
// root (one root bit per stage, 25 stages) followed by the restoring dividers
// (one quotient bit per stage, 32 stages), plus the multiply, discriminant,
// numerator and clamp stages.
// Reset clears all valid bits, so no stale result is strobed; words in flight
// at reset are dropped.
// root_kind: 0 two real roots, 1 double root, 2 complex pair, 3 a is zero.
// Values are signed Q16.16, clamped to 32 bits with saturated set on a clip.
`include "quadratic_root_solver_top_assert.svh"

module quadratic_root_solver_top
    import qrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  qrs_in_t  coef,
    output logic     done,
    output qrs_out_t result
);

    logic accept;

    logic                     busy_reg;
    logic                     m_valid_reg;
    logic signed [COEF_W-1:0] m_a_reg;
    logic signed [COEF_W-1:0] m_b_reg;
    logic signed [2*COEF_W-1:0] m_bb_reg;
    logic signed [2*COEF_W-1:0] m_ac_reg;

    logic signed [DISC_W-1:0] disc;
    logic [DISC_W-1:0]        disc_mag;
    qrs_side_t                side_next;

    logic             sq_valid_reg [0:SQ_W];
    logic [RAD_W-1:0] sq_rad_reg   [0:SQ_W];
    logic [REM_W-1:0] sq_rem_reg   [0:SQ_W];
    logic [SQ_W-1:0]  sq_root_reg  [0:SQ_W];
    qrs_side_t        sq_side_reg  [0:SQ_W];
    logic [REM_W+1:0] sq_sh        [0:SQ_W-1];
    logic [REM_W+1:0] sq_trial     [0:SQ_W-1];
    logic             sq_ge        [0:SQ_W-1];

    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
    logic signed [NUM_W-1:0] negb_ext;
    logic signed [NUM_W-1:0] root_ext;
    logic [NUM_W-1:0]        n1_mag;
    logic [NUM_W-1:0]        n2_mag;
    logic                    n2_dneg;

    logic                         dv_valid_reg [0:QUO_W];
    logic [1:0][QUO_W-1:0]        dv_dvd_reg   [0:QUO_W];
    logic [1:0][DIV_W-1:0]        dv_rem_reg   [0:QUO_W];
    qrs_dside_t                   dv_side_reg  [0:QUO_W];
    logic [1:0][DIV_W:0]          dv_sh        [0:QUO_W-1];
    logic [1:0]                   dv_ge        [0:QUO_W-1];

    logic [1:0][VAL_W-1:0] fin_val;
    logic [1:0]            fin_clip;

    logic     done_reg;
    qrs_out_t result_reg;
    qrs_out_t result_next;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // Hold off words after reset until the first clock edge clears busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Multiply stage: b*b and a*c
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        m_a_reg  <= coef.coef_a;
        m_b_reg  <= coef.coef_b;
        m_bb_reg <= coef.coef_b * coef.coef_b;
        m_ac_reg <= coef.coef_a * coef.coef_c;
    end

    // Discriminant, kind and square root radicand
    always_comb
    begin
        disc     = DISC_W'(m_bb_reg) - $signed({m_ac_reg, 2'b00});
        disc_mag = disc[DISC_W-1] ? DISC_W'(-disc) : DISC_W'(disc);
        if (m_a_reg == '0)
        begin
            side_next.kind = KIND_A_ZERO;
        end
        else if (disc[DISC_W-1])
        begin
            side_next.kind = KIND_COMPLEX;
        end
        else if (disc == '0)
        begin
            side_next.kind = KIND_DOUBLE;
        end
        else
        begin
            side_next.kind = KIND_TWO_REAL;
        end
        side_next.a_neg = m_a_reg[COEF_W-1];
        side_next.a_mag = m_a_reg[COEF_W-1] ? DIV_W'(-m_a_reg) : DIV_W'(m_a_reg);
        side_next.negb  = (NUM_W-1)'(0) - $signed({m_b_reg[COEF_W-1], m_b_reg, 8'h00});
    end

    // Square root stages: one root bit each
    always_comb
    begin
        for (int i = 0; i < SQ_W; i++)
        begin
            sq_sh[i]    = {sq_rem_reg[i], sq_rad_reg[i][RAD_W-1 -: 2]};
            sq_trial[i] = (REM_W+2)'({sq_root_reg[i], 2'b01});
            sq_ge[i]    = sq_sh[i] >= sq_trial[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQ_W; i++)
            begin
                sq_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sq_valid_reg[0] <= m_valid_reg;
            for (int i = 0; i < SQ_W; i++)
            begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_rad_reg[0]  <= {disc_mag, 16'h0000};
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_side_reg[0] <= side_next;
        for (int i = 0; i < SQ_W; i++)
        begin
            sq_rad_reg[i+1]  <= sq_rad_reg[i] << 2;
            sq_rem_reg[i+1]  <= sq_ge[i] ? REM_W'(sq_sh[i] - sq_trial[i]) : REM_W'(sq_sh[i]);
            sq_root_reg[i+1] <= {sq_root_reg[i][SQ_W-2:0], sq_ge[i]};
            sq_side_reg[i+1] <= sq_side_reg[i];
        end
    end

    // Numerators and quotient signs
    always_comb
    begin
        negb_ext = NUM_W'(sq_side_reg[SQ_W].negb);
        root_ext = $signed({1'b0, sq_root_reg[SQ_W]});
        n2_dneg  = sq_side_reg[SQ_W].a_neg;
        case (sq_side_reg[SQ_W].kind)
            KIND_TWO_REAL:
            begin
                n1 = negb_ext + root_ext;
                n2 = negb_ext - root_ext;
            end
            KIND_DOUBLE:
            begin
                n1 = negb_ext;
                n2 = negb_ext;
            end
            KIND_COMPLEX:
            begin
                n1      = negb_ext;
                n2      = root_ext;
                n2_dneg = 1'b0;
            end
            default:
            begin
                n1 = '0;
                n2 = '0;
            end
        endcase
        n1_mag = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
        n2_mag = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
    end

    // Divider stages: one quotient bit per lane each
    always_comb
    begin
        for (int i = 0; i < QUO_W; i++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv_sh[i][l] = {dv_rem_reg[i][l], dv_dvd_reg[i][l][QUO_W-1]};
                dv_ge[i][l] = dv_sh[i][l] >= {1'b0, dv_side_reg[i].dsr};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_W; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_W];
            for (int i = 0; i < QUO_W; i++)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_dvd_reg[0][0]   <= {n1_mag[NUM_W-2:0], 7'b0000000};
        dv_dvd_reg[0][1]   <= {n2_mag[NUM_W-2:0], 7'b0000000};
        dv_rem_reg[0]      <= '0;
        dv_side_reg[0].kind <= sq_side_reg[SQ_W].kind;
        dv_side_reg[0].neg  <= {n2[NUM_W-1] ^ n2_dneg, n1[NUM_W-1] ^ sq_side_reg[SQ_W].a_neg};
        dv_side_reg[0].dsr  <= sq_side_reg[SQ_W].a_mag;
        for (int i = 0; i < QUO_W; i++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv_rem_reg[i+1][l] <= dv_ge[i][l] ? DIV_W'(dv_sh[i][l] - {1'b0, dv_side_reg[i].dsr})
                                                  : DIV_W'(dv_sh[i][l]);
                dv_dvd_reg[i+1][l] <= {dv_dvd_reg[i][l][QUO_W-2:0], dv_ge[i][l]};
            end
            dv_side_reg[i+1] <= dv_side_reg[i];
        end
    end

    // Apply sign and clamp to 32 bits; drop the quotient when a is zero
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (dv_side_reg[QUO_W].kind == KIND_A_ZERO)
            begin
                fin_clip[l] = 1'b0;
                fin_val[l]  = '0;
            end
            else if (dv_side_reg[QUO_W].neg[l])
            begin
                fin_clip[l] = dv_dvd_reg[QUO_W][l] > 32'h8000_0000;
                fin_val[l]  = fin_clip[l] ? 32'h8000_0000 : VAL_W'(-dv_dvd_reg[QUO_W][l]);
            end
            else
            begin
                fin_clip[l] = dv_dvd_reg[QUO_W][l][QUO_W-1];
                fin_val[l]  = fin_clip[l] ? 32'h7FFF_FFFF : dv_dvd_reg[QUO_W][l];
            end
        end
        result_next.root_kind    = dv_side_reg[QUO_W].kind;
        result_next.first_value  = $signed(fin_val[0]);
        result_next.second_value = $signed(fin_val[1]);
        result_next.saturated    = fin_clip[0] | fin_clip[1];
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Checks
    `QRS_ASSERT_IMPL(a_latency, done, $past(start && !busy, PIPE_LAT))
    `QRS_ASSERT_NEXT(a_busy_low, !busy, !busy)
    `QRS_ASSERT_IMPL(a_zero_lead, done && result.root_kind == KIND_A_ZERO, result.first_value == '0 && result.second_value == '0 && !result.saturated)
    `QRS_ASSERT_IMPL(a_double_eq, done && result.root_kind == KIND_DOUBLE, result.first_value == result.second_value)
    `QRS_ASSERT_IMPL(a_imag_pos, done && result.root_kind == KIND_COMPLEX, !result.second_value[VAL_W-1])

endmodule
